[rtl/pad_probe_sample_classifier_unit_assert.svh]
// Assertion macros for the pad probe sample classifier.
`ifndef PAD_PROBE_SAMPLE_CLASSIFIER_UNIT_ASSERT_SVH
`define PAD_PROBE_SAMPLE_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTH
// prop holds at every edge outside reset
`define PPSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cond at one edge implies prop at the next
`define PPSC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define PPSC_ASSERT(label, clk, rst, prop, msg)
`define PPSC_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

[rtl/ppsc_pkg.sv]
`default_nettype none
package ppsc_pkg;

  typedef struct packed {
    logic [3:0] nib_high_phase;
    logic [3:0] nib_low_phase;
    logic       left_bit_high;
    logic       right_bit_high;
    logic       left_bit_low;
    logic       right_bit_low;
  } ppsc_sample_t;

  typedef struct packed {
    logic [6:0]  activity_count;
    logic [6:0]  type_a_count;
    logic [6:0]  type_b_count;
    logic [5:0]  stable_mask;
    logic [11:0] first_sample;
    logic [11:0] final_sample;
    logic        window_done;
  } ppsc_result_t;

  // classified sample as it sits in the queue
  typedef struct packed {
    logic [11:0] packed_sample;
    logic        act_hit;
    logic        type_a_hit;
    logic        type_b_hit;
  } ppsc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ppsc_qstat_t;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [3:0] NIB_IDLE   = 4'hF;
  localparam logic [3:0] A_MASK     = 4'h7;
  localparam logic [3:0] A_CODE     = 4'h4;
  localparam logic [3:0] B_LOW_MASK = 4'hC;
  localparam logic [3:0] A_PAIR     = 4'h1;
  localparam logic [3:0] X_HIGH     = 4'h2;
  localparam logic [3:0] X_LOW      = 4'h3;
  localparam logic [5:0] FLAGS_ALL  = 6'h3F;

endpackage
`default_nettype wire

[rtl/pad_probe_sample_classifier_unit.sv]
// Pad probe sample classifier.
// Sample channel: sample_valid / sample_stall / sample carries one probe
// sample per transaction (both nibbles and four handshake bits).
// Result channel: result_valid / result_stall / result carries one result
// per sample: running activity, type A and type B counts (saturating at
// SAMPLES), six stability flags, the window's first sample, and on the
// window's last sample final_sample and window_done.
// Throughput: one sample per cycle while the receiver does not stall; the
// front classifies and writes a two-entry queue, the back pops one entry
// per cycle into the result register. When the receiver stalls the result
// holds, the queue fills, and sample_stall rises once both queue entries
// are taken.
// Reset (rst, synchronous) empties the queue, drops result_valid and starts
// a new window with cleared counters and all stability flags set.
`default_nettype none
`include "pad_probe_sample_classifier_unit_assert.svh"
module pad_probe_sample_classifier_unit
  import ppsc_pkg::*;
#(
  parameter int SAMPLES = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          sample_valid,
  output logic         sample_stall,
  input  var ppsc_sample_t sample,
  output logic         result_valid,
  input  wire          result_stall,
  output ppsc_result_t result
);

  ppsc_item_t  front_item;
  ppsc_item_t  head;
  ppsc_qstat_t qstat;
  logic        pop;

  assign sample_stall = qstat.full;

  ppsc_front u_front (
    .sample (sample),
    .item   (front_item)
  );

  ppsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (sample_valid),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ppsc_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item         (head),
    .item_valid   (!qstat.empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `PPSC_ASSERT(a_queue_state, clk, rst, !(qstat.full && qstat.empty), "queue full and empty")
  `PPSC_ASSERT(a_final_zero, clk, rst, !(result_valid && !result.window_done) || (result.final_sample == 12'd0), "final_sample set off window end")
  `PPSC_ASSERT(a_count_limit, clk, rst, !result_valid || ((result.activity_count <= 7'(SAMPLES)) && (result.type_a_count <= 7'(SAMPLES)) && (result.type_b_count <= 7'(SAMPLES))), "counter above limit")
  `PPSC_ASSERT_NEXT(a_hold_on_stall, clk, rst, result_valid && result_stall && qstat.full, qstat.full, "queue drained while output stalled")

endmodule
`default_nettype wire

[rtl/ppsc_front.sv]
`default_nettype none
module ppsc_front
  import ppsc_pkg::*;
(
  input  var ppsc_sample_t sample,
  output ppsc_item_t       item
);

  logic [3:0] nh;
  logic [3:0] nl;
  logic       idle;
  logic       is_a;
  logic       is_x;

  assign nh   = sample.nib_high_phase;
  assign nl   = sample.nib_low_phase;
  assign idle = (nh == NIB_IDLE) && (nl == NIB_IDLE) &&
                sample.left_bit_high && sample.left_bit_low;
  assign is_a = ((nh & A_MASK) == A_CODE) || ((nh == A_PAIR) && (nl == A_PAIR));
  assign is_x = (nh == X_HIGH) && (nl == X_LOW);

  always_comb begin
    item.packed_sample = {nh, nl, sample.left_bit_high, sample.right_bit_high,
                          sample.left_bit_low, sample.right_bit_low};
    item.act_hit    = !idle || (sample.right_bit_high != sample.right_bit_low);
    item.type_a_hit = is_a;
    item.type_b_hit = !is_a && !is_x && ((nl & B_LOW_MASK) == 4'h0) &&
                      ((nh != NIB_IDLE) || (nl != NIB_IDLE) ||
                       (sample.left_bit_high != sample.left_bit_low) ||
                       (sample.right_bit_high != sample.right_bit_low));
  end

endmodule
`default_nettype wire

[rtl/ppsc_queue.sv]
`default_nettype none
module ppsc_queue
  import ppsc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  var ppsc_item_t push_item,
  input  wire         pop,
  output ppsc_item_t  head,
  output ppsc_qstat_t qstat
);

  ppsc_item_t       slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/ppsc_back.sv]
`default_nettype none
module ppsc_back
  import ppsc_pkg::*;
#(
  parameter int SAMPLES = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  var ppsc_item_t item,
  input  wire          item_valid,
  output logic         pop,
  output logic         result_valid,
  input  wire          result_stall,
  output ppsc_result_t result
);

  localparam int         IW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [6:0] SAT = 7'(SAMPLES);
  localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLES - 1);

  logic [IW-1:0] sample_index;
  logic [11:0]   first_capture;
  logic [5:0]    stability_flags;
  logic [6:0]    activity_counter;
  logic [6:0]    type_a_counter;
  logic [6:0]    type_b_counter;

  logic          start;
  logic          last;
  logic [11:0]   first_next;
  logic [11:0]   diff;
  logic [5:0]    flags_next;
  logic [6:0]    act_next;
  logic [6:0]    a_next;
  logic [6:0]    b_next;

  function automatic logic [6:0] bump(input logic [6:0] c, input logic hit, input logic clr);
    logic [6:0] base;
    base = clr ? 7'd0 : c;
    if (hit && (base < SAT)) return base + 7'd1;
    return base;
  endfunction

  assign pop   = item_valid && (!result_valid || !result_stall);
  assign start = (sample_index == '0);
  assign last  = (sample_index == LAST_IDX);

  always_comb begin
    first_next = start ? item.packed_sample : first_capture;
    diff       = item.packed_sample ^ first_next;
    flags_next = start ? FLAGS_ALL : stability_flags;
    if (!last) begin
      flags_next = flags_next & ~{|diff[11:8], |diff[7:4], diff[3], diff[2],
                                  diff[1], diff[0]};
    end
    act_next = bump(activity_counter, item.act_hit, start);
    a_next   = bump(type_a_counter, item.type_a_hit, start);
    b_next   = bump(type_b_counter, item.type_b_hit, start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index     <= '0;
      first_capture    <= '0;
      stability_flags  <= FLAGS_ALL;
      activity_counter <= '0;
      type_a_counter   <= '0;
      type_b_counter   <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (pop) begin
        sample_index     <= last ? '0 : sample_index + 1'b1;
        first_capture    <= first_next;
        stability_flags  <= flags_next;
        activity_counter <= act_next;
        type_a_counter   <= a_next;
        type_b_counter   <= b_next;
        result_valid     <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.activity_count <= act_next;
      result.type_a_count   <= a_next;
      result.type_b_count   <= b_next;
      result.stable_mask    <= flags_next;
      result.first_sample   <= first_next;
      result.final_sample   <= last ? item.packed_sample : 12'd0;
      result.window_done    <= last;
    end
  end

endmodule
`default_nettype wire

[bench/tb_pad_probe_sample_classifier_unit.sv]
module tb_pad_probe_sample_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ppsc_pkg::*;

  localparam int WINDOW      = 8;
  localparam int CYCLE_LIMIT = 200000;

  // nibble values that steer the classifier into its pattern branches
  localparam logic [3:0] HOT_NIBBLES [7] =
    '{NIB_IDLE, A_CODE, A_CODE | 4'h8, A_PAIR, X_HIGH, X_LOW, 4'h0};

  // idle, activity by right-bit mismatch, left-bit mismatch, type A/B/neither,
  // then a window that stays steady until its last sample
  localparam logic [11:0] DIRECTED [20] = '{
    12'hFFF, 12'hFFE, 12'hFF7, 12'h000, 12'h400, 12'hC00, 12'h110, 12'h230,
    12'h5A5, 12'h5A5, 12'h5A5, 12'h5A5, 12'h5A5, 12'h5A5, 12'h5A5, 12'h000,
    12'h220, 12'hF0F, 12'hF3A, 12'h0FF
  };

  class probe_window_scoreboard;
    ppsc_result_t expected_q[$];
    int           errors;
    logic [5:0]   pos;
    logic [11:0]  first_cap;
    logic [11:0]  last_cap;
    logic [5:0]   flags;
    logic [6:0]   act_cnt;
    logic [6:0]   type_a_cnt;
    logic [6:0]   type_b_cnt;

    function new();
      errors     = 0;
      pos        = '0;
      first_cap  = '0;
      last_cap   = '0;
      flags      = FLAGS_ALL;
      act_cnt    = '0;
      type_a_cnt = '0;
      type_b_cnt = '0;
    endfunction

    function logic [6:0] bump(logic [6:0] c);
      return (c < WINDOW) ? c + 7'd1 : 7'(WINDOW);
    endfunction

    function void note_sample(ppsc_sample_t s);
      logic [11:0]  p;
      logic [11:0]  d;
      logic         last;
      logic         idle;
      ppsc_result_t e;
      p    = s;
      last = (int'(pos) + 1 >= WINDOW);
      if (pos == 0) begin
        act_cnt    = '0;
        type_a_cnt = '0;
        type_b_cnt = '0;
        flags      = FLAGS_ALL;
        first_cap  = p;
      end
      if (last) begin
        last_cap = p;
      end else begin
        d     = p ^ first_cap;
        flags = flags & ~{|d[11:8], |d[7:4], d[3], d[2], d[1], d[0]};
      end
      idle = (s.nib_high_phase == NIB_IDLE) && (s.nib_low_phase == NIB_IDLE) &&
             s.left_bit_high && s.left_bit_low;
      if (!idle || (s.right_bit_high != s.right_bit_low))
        act_cnt = bump(act_cnt);
      if (((s.nib_high_phase & A_MASK) == A_CODE) ||
          (s.nib_high_phase == A_PAIR && s.nib_low_phase == A_PAIR)) begin
        type_a_cnt = bump(type_a_cnt);
      end else if (!(s.nib_high_phase == X_HIGH && s.nib_low_phase == X_LOW) &&
                   ((s.nib_low_phase & B_LOW_MASK) == 4'h0) &&
                   (s.nib_high_phase != NIB_IDLE || s.nib_low_phase != NIB_IDLE ||
                    s.left_bit_high != s.left_bit_low ||
                    s.right_bit_high != s.right_bit_low)) begin
        type_b_cnt = bump(type_b_cnt);
      end
      e.activity_count = act_cnt;
      e.type_a_count   = type_a_cnt;
      e.type_b_count   = type_b_cnt;
      e.stable_mask    = flags;
      e.first_sample   = first_cap;
      e.final_sample   = last ? last_cap : 12'h000;
      e.window_done    = last;
      expected_q.push_back(e);
      pos = last ? 6'd0 : pos + 6'd1;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(ppsc_result_t got);
      ppsc_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", got, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.activity_count !== want.activity_count)
        report_mismatch("activity_count", got.activity_count, want.activity_count);
      if (got.type_a_count !== want.type_a_count)
        report_mismatch("type_a_count", got.type_a_count, want.type_a_count);
      if (got.type_b_count !== want.type_b_count)
        report_mismatch("type_b_count", got.type_b_count, want.type_b_count);
      if (got.stable_mask !== want.stable_mask)
        report_mismatch("stable_mask", got.stable_mask, want.stable_mask);
      if (got.first_sample !== want.first_sample)
        report_mismatch("first_sample", got.first_sample, want.first_sample);
      if (got.final_sample !== want.final_sample)
        report_mismatch("final_sample", got.final_sample, want.final_sample);
      if (got.window_done !== want.window_done)
        report_mismatch("window_done", got.window_done, want.window_done);
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         sample_valid = 1'b0;
  logic         sample_stall;
  ppsc_sample_t sample = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  ppsc_result_t result;

  probe_window_scoreboard sb = new();
  int gap_pct    = 0;
  int stall_pct  = 0;
  int sent_count = 0;
  int cycle_count = 0;

  pad_probe_sample_classifier_unit #(.SAMPLES(WINDOW)) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(result);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_sample(input ppsc_sample_t s);
    while ($urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(s);
    sent_count++;
  endtask

  // hold off the sender until every pending result has been taken
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic ppsc_sample_t random_sample();
    ppsc_sample_t s;
    s = ppsc_sample_t'(12'($urandom_range(4095)));
    case ($urandom_range(5))
      0, 1: begin
        s.nib_high_phase = HOT_NIBBLES[$urandom_range(6)];
        s.nib_low_phase  = HOT_NIBBLES[$urandom_range(6)];
      end
      2: begin
        s.nib_high_phase = NIB_IDLE;
        s.nib_low_phase  = NIB_IDLE;
        s.left_bit_high  = 1'b1;
        s.left_bit_low   = 1'b1;
      end
      3: begin
        if ($urandom_range(1) == 0) begin
          s.nib_high_phase = A_PAIR;
          s.nib_low_phase  = A_PAIR;
        end else begin
          s.nib_high_phase = X_HIGH;
          s.nib_low_phase  = X_LOW;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // most windows repeat one sample with an occasional bit flip so the
  // stability flags survive long enough to matter
  task automatic run_random(input int n, input int gap, input int stall);
    ppsc_sample_t base;
    ppsc_sample_t s;
    logic         steady;
    gap_pct   = gap;
    stall_pct = stall;
    steady    = 1'b0;
    base      = '0;
    for (int i = 0; i < n; i++) begin
      if (sent_count % WINDOW == 0) begin
        steady = ($urandom_range(99) < 60);
        base   = random_sample();
      end
      s = steady ? base : random_sample();
      if (steady && $urandom_range(4) == 0)
        s = ppsc_sample_t'(base ^ (12'h1 << $urandom_range(11)));
      send_sample(s);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct   = 20;
    stall_pct = 40;
    foreach (DIRECTED[i])
      send_sample(ppsc_sample_t'(DIRECTED[i]));
    drain_results();

    run_random(150, 30, 85);
    run_random(150, 85, 30);
    drain_results();
    run_random(150, 0, 0);

    sample_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ppsc_pkg.sv
rtl/ppsc_front.sv
rtl/ppsc_queue.sv
rtl/ppsc_back.sv
rtl/pad_probe_sample_classifier_unit.sv
bench/tb_pad_probe_sample_classifier_unit.sv
